// ----- rtl/core/pidpi_pkg.sv -----
// Package for the positional/incremental PID controller.
// Holds the control word layout, the microcode ROM and the fixed-point helpers.
// Depends on nothing; used by pid_position_incremental.
`default_nettype none

package pidpi_pkg;

  // Register indexes on the configuration port (byte address / 4)
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_GAINP = 3'd1;
  localparam logic [2:0] REG_GAINI = 3'd2;
  localparam logic [2:0] REG_GAIND = 3'd3;
  localparam logic [2:0] REG_ALPHA = 3'd4;

  // 0.92 and 1.08 in unsigned Q2.16, integral limit of +-1000.0 in Q.4
  localparam logic [17:0] K092 = 18'd60293;
  localparam logic [17:0] K108 = 18'd70779;
  localparam logic signed [16:0] INT_LIMIT = 17'sd16000;

  localparam int PcW = 4;

  typedef enum logic [2:0] {
    A_W, A_ALPHA, A_TMP, A_K092, A_K108, A_GP, A_GI, A_GD
  } a_sel_t;

  typedef enum logic [2:0] {
    B_GD, B_DF, B_DIF, B_E, B_INT, B_EN, B_EP
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    DIF_HOLD, DIF_E_EP, DIF_N_L, DIF_2ND
  } dif_op_t;

  typedef enum logic [2:0] {
    HIST_NONE, HIST_POS_IN, HIST_POS_SHIFT, HIST_EP2, HIST_EP, HIST_EN
  } hist_op_t;

  typedef enum logic [1:0] {
    OUT_NONE, OUT_ACC_PROD, OUT_ACC_DF
  } out_op_t;

  typedef enum logic [1:0] {
    FLOW_NEXT, FLOW_BRANCH, FLOW_DONE
  } flow_t;

  typedef struct packed {
    a_sel_t         a_sel;
    b_sel_t         b_sel;
    logic           tmp_we;
    acc_op_t        acc_op;
    dif_op_t        dif_op;
    hist_op_t       hist_op;
    logic           df_we;
    out_op_t        out_op;
    flow_t          flow;
    logic [PcW-1:0] target;
  } uop_t;

  localparam logic [PcW-1:0] PC_INCR = 4'd8;

  // Microcode: step 0 dispatches on mode, positional runs 1..7, incremental 8..14.
  // Every multiply lands in the product register and is consumed one step later.
  function automatic uop_t uop_rom(input logic [PcW-1:0] pc);
    uop_t u;
    u = '{a_sel: A_K092, b_sel: B_EP, tmp_we: 1'b0, acc_op: ACC_HOLD,
          dif_op: DIF_HOLD, hist_op: HIST_NONE, df_we: 1'b0, out_op: OUT_NONE,
          flow: FLOW_NEXT, target: '0};
    unique case (pc)
      4'd0: begin
        u.a_sel = A_K092; u.b_sel = B_EP; u.flow = FLOW_BRANCH; u.target = PC_INCR;
      end
      4'd1: begin
        u.a_sel = A_W; u.b_sel = B_GD; u.hist_op = HIST_POS_IN; u.dif_op = DIF_E_EP;
      end
      4'd2: begin
        u.tmp_we = 1'b1; u.a_sel = A_ALPHA; u.b_sel = B_DF;
      end
      4'd3: begin
        u.acc_op = ACC_LOAD; u.a_sel = A_TMP; u.b_sel = B_DIF;
      end
      4'd4: begin
        u.acc_op = ACC_ADD; u.a_sel = A_GP; u.b_sel = B_E;
      end
      4'd5: begin
        u.df_we = 1'b1; u.acc_op = ACC_LOAD; u.a_sel = A_GI; u.b_sel = B_INT;
        u.hist_op = HIST_POS_SHIFT;
      end
      4'd6: begin
        u.acc_op = ACC_ADD;
      end
      4'd7: begin
        u.out_op = OUT_ACC_DF; u.flow = FLOW_DONE;
      end
      4'd8: begin
        u.hist_op = HIST_EP2; u.a_sel = A_K092; u.b_sel = B_EN;
      end
      4'd9: begin
        u.hist_op = HIST_EP; u.a_sel = A_K108; u.b_sel = B_E;
      end
      4'd10: begin
        u.hist_op = HIST_EN;
      end
      4'd11: begin
        u.dif_op = DIF_N_L; u.a_sel = A_GI; u.b_sel = B_EN;
      end
      4'd12: begin
        u.acc_op = ACC_LOAD; u.dif_op = DIF_2ND; u.a_sel = A_GP; u.b_sel = B_DIF;
      end
      4'd13: begin
        u.acc_op = ACC_ADD; u.a_sel = A_GD; u.b_sel = B_DIF;
      end
      4'd14: begin
        u.out_op = OUT_ACC_PROD; u.flow = FLOW_DONE;
      end
      default: begin
        u.flow = FLOW_DONE;
      end
    endcase
    return u;
  endfunction

  // Clip a wide signed value to the 32-bit range
  function automatic logic [31:0] sat32(input logic signed [55:0] x);
    logic [31:0] r;
    if (x > 56'sh7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -56'sh8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pid_position_incremental.sv -----
// PID controller, positional or incremental, run by a microcoded sequencer.
// Uses pidpi_pkg for the control word, microcode ROM and saturation helper.
// Fixed-point datapath with one shared 33x32 multiplier.
//
// Usage:
//   in_* channel: one request per control tick, in_tdata = error_sample (Q11.4).
//   out_* channel: one request per input, out_tdata = drive_value (Q12).
//   cfg_* port: APB writes to mode (0x00), gain_p (0x04), gain_i (0x08),
//   gain_d (0x0C) and deriv_alpha (0x10); change them only while idle.
// Sequencing: each request runs 8 microcode steps (a dispatch step plus seven
//   steps of the chosen mode), set by the single multiplier that every
//   product goes through. The result is written to the output register on
//   the final step; one request is in flight at a time, so a new input is
//   taken only once the previous request has finished its final step.
// in_tready is high whenever the sequencer is idle, also while a finished
//   result still waits in the output register.
// Stall: if the receiver holds out_tready low, the sequencer waits on its
//   final step until the output register frees up.
// Reset: rst_n (synchronous) clears registers, error history, integral and
//   filtered derivative; the block then takes input at once.
`default_nettype none

module pid_position_incremental (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,     // [15:0] error_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,    // [31:0] drive_value
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // configuration
  logic               mode_r;
  logic signed [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [15:0]        alpha_r;

  // sequencer
  logic                         busy_r;
  logic [pidpi_pkg::PcW-1:0]    pc_r;
  pidpi_pkg::uop_t              uop;
  logic                         advance;

  // datapath
  logic signed [15:0] e_r;
  logic signed [19:0] en_r, ep_r, ep2_r;
  logic signed [15:0] int_r;
  logic signed [31:0] df_r;
  logic signed [32:0] tmp_r;
  logic signed [21:0] dif_r;
  logic signed [55:0] prod_r, acc_r;
  logic [31:0]        out_data_r;
  logic               out_valid_r;

  logic signed [32:0] a_op;
  logic signed [31:0] b_op;
  logic signed [64:0] mul;
  logic [16:0]        w_alpha;
  logic signed [16:0] isum, iclamp;
  logic signed [55:0] prod_rnd, acc_rnd, out_sum;
  logic signed [19:0] hist_rnd;
  logic signed [39:0] df_rnd;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      alpha_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pidpi_pkg::REG_MODE:  mode_r   <= cfg_pwdata[0];
        pidpi_pkg::REG_GAINP: gain_p_r <= cfg_pwdata[15:0];
        pidpi_pkg::REG_GAINI: gain_i_r <= cfg_pwdata[15:0];
        pidpi_pkg::REG_GAIND: gain_d_r <= cfg_pwdata[15:0];
        pidpi_pkg::REG_ALPHA: alpha_r  <= cfg_pwdata[15:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pidpi_pkg::REG_MODE:  cfg_prdata = {31'd0, mode_r};
      pidpi_pkg::REG_GAINP: cfg_prdata = {16'd0, gain_p_r};
      pidpi_pkg::REG_GAINI: cfg_prdata = {16'd0, gain_i_r};
      pidpi_pkg::REG_GAIND: cfg_prdata = {16'd0, gain_d_r};
      pidpi_pkg::REG_ALPHA: cfg_prdata = {16'd0, alpha_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign uop       = pidpi_pkg::uop_rom(pc_r);
  assign in_tready = !busy_r;
  // hold the final step while the output register is still full
  assign advance   = busy_r && !(uop.flow == pidpi_pkg::FLOW_DONE
                                 && out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_tvalid && in_tready) begin
        busy_r <= 1'b1;
        pc_r   <= '0;
      end else if (advance) begin
        unique case (uop.flow)
          pidpi_pkg::FLOW_NEXT:   pc_r <= pc_r + 1'b1;
          pidpi_pkg::FLOW_BRANCH: pc_r <= mode_r ? uop.target : pc_r + 1'b1;
          pidpi_pkg::FLOW_DONE: begin
            pc_r        <= '0;
            busy_r      <= 1'b0;
            out_valid_r <= 1'b1;
          end
          default: pc_r <= '0;
        endcase
      end
    end
  end

  // ---------------- datapath ----------------
  assign w_alpha = 17'h1_0000 - {1'b0, alpha_r};

  always_comb begin
    unique case (uop.a_sel)
      pidpi_pkg::A_W:     a_op = $signed({16'd0, w_alpha});
      pidpi_pkg::A_ALPHA: a_op = $signed({17'd0, alpha_r});
      pidpi_pkg::A_TMP:   a_op = tmp_r;
      pidpi_pkg::A_K092:  a_op = $signed({15'd0, pidpi_pkg::K092});
      pidpi_pkg::A_K108:  a_op = $signed({15'd0, pidpi_pkg::K108});
      pidpi_pkg::A_GP:    a_op = 33'(gain_p_r);
      pidpi_pkg::A_GI:    a_op = 33'(gain_i_r);
      pidpi_pkg::A_GD:    a_op = 33'(gain_d_r);
      default:            a_op = '0;
    endcase
    unique case (uop.b_sel)
      pidpi_pkg::B_GD:  b_op = 32'(gain_d_r);
      pidpi_pkg::B_DF:  b_op = df_r;
      pidpi_pkg::B_DIF: b_op = 32'(dif_r);
      pidpi_pkg::B_E:   b_op = 32'(e_r);
      pidpi_pkg::B_INT: b_op = 32'(int_r);
      pidpi_pkg::B_EN:  b_op = 32'(en_r);
      pidpi_pkg::B_EP:  b_op = 32'(ep_r);
      default:          b_op = '0;
    endcase
  end

  assign mul = a_op * b_op;

  // round half up after the 2^-16 rescale
  assign prod_rnd = prod_r + 56'sd32768;
  assign hist_rnd = prod_rnd[35:16];
  assign acc_rnd  = acc_r + 56'sd32768;
  assign df_rnd   = acc_rnd[55:16];

  assign isum   = 17'(int_r) + 17'(e_r);
  always_comb begin
    if (isum > pidpi_pkg::INT_LIMIT) begin
      iclamp = pidpi_pkg::INT_LIMIT;
    end else if (isum < -pidpi_pkg::INT_LIMIT) begin
      iclamp = -pidpi_pkg::INT_LIMIT;
    end else begin
      iclamp = isum;
    end
  end

  assign out_sum = acc_r + ((uop.out_op == pidpi_pkg::OUT_ACC_DF) ? 56'(df_r) : prod_r);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      e_r <= in_tdata;
    end
    if (advance) begin
      prod_r <= mul[55:0];
      if (uop.tmp_we) begin
        tmp_r <= prod_r[32:0];
      end
      unique case (uop.acc_op)
        pidpi_pkg::ACC_LOAD: acc_r <= prod_r;
        pidpi_pkg::ACC_ADD:  acc_r <= acc_r + prod_r;
        default: ;
      endcase
      unique case (uop.dif_op)
        pidpi_pkg::DIF_E_EP: dif_r <= 22'(e_r) - 22'(ep_r);
        pidpi_pkg::DIF_N_L:  dif_r <= 22'(en_r) - 22'(ep_r);
        pidpi_pkg::DIF_2ND:  dif_r <= 22'(en_r) - (22'(ep_r) <<< 1) + 22'(ep2_r);
        default: ;
      endcase
      if (uop.out_op != pidpi_pkg::OUT_NONE) begin
        out_data_r <= pidpi_pkg::sat32(out_sum);
      end
    end
  end

  // history, integral and filtered derivative carry state across items, so they reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= '0;
      ep_r  <= '0;
      ep2_r <= '0;
      int_r <= '0;
      df_r  <= '0;
    end else if (advance) begin
      if (uop.df_we) begin
        df_r <= pidpi_pkg::sat32(56'(df_rnd));
      end
      unique case (uop.hist_op)
        pidpi_pkg::HIST_POS_IN: begin
          en_r  <= 20'(e_r);
          int_r <= iclamp[15:0];
        end
        pidpi_pkg::HIST_POS_SHIFT: ep_r  <= en_r;
        pidpi_pkg::HIST_EP2:       ep2_r <= hist_rnd;
        pidpi_pkg::HIST_EP:        ep_r  <= hist_rnd;
        pidpi_pkg::HIST_EN:        en_r  <= hist_rnd;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_int_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (int_r <= 16'sd16000) && (int_r >= -16'sd16000))
    else $error("integral outside clamp range");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (busy_r && pc_r == '0))
    else $error("accepted request did not start at step zero");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r && uop.flow == pidpi_pkg::FLOW_DONE))
    else $error("result appeared without a final step");

  a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (pc_r == '0))
    else $error("step counter moved while idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for pid_position_incremental: drives error samples on the input
// stream and APB register writes, and checks every drive value against its own predictor.
// Depends on pidpi_pkg for the register indexes and on the RTL of the block.

// Tracks the controller state and the queue of drive values still to arrive
class drive_scoreboard;
  localparam logic signed [63:0] SCALE_092 = 64'sd60293;
  localparam logic signed [63:0] SCALE_108 = 64'sd70779;
  localparam logic signed [63:0] INTEG_MAX = 64'sd16000;

  bit                 mode_incr;
  logic signed [15:0] kp, ki, kd;
  logic        [15:0] alpha;
  logic signed [19:0] err_cur, err_last, err_last2;
  logic signed [15:0] integ;
  logic signed [31:0] deriv;
  logic        [31:0] drive_due[$];
  int                 errors;

  function new();
    mode_incr = 1'b0;
    kp = '0;
    ki = '0;
    kd = '0;
    alpha = '0;
    err_cur = '0;
    err_last = '0;
    err_last2 = '0;
    integ = '0;
    deriv = '0;
    errors = 0;
  endfunction

  // Rescale by 2^-16, rounding half up
  function logic signed [63:0] round_q16(logic signed [63:0] x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function logic signed [63:0] clip32(logic signed [63:0] x);
    if (x > 64'sh7FFF_FFFF) begin
      return 64'sh7FFF_FFFF;
    end
    if (x < -64'sh8000_0000) begin
      return -64'sh8000_0000;
    end
    return x;
  endfunction

  function logic signed [63:0] wrap20(logic signed [63:0] x);
    logic signed [19:0] t;
    t = x[19:0];
    return t;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      pidpi_pkg::REG_MODE:  mode_incr = data[0];
      pidpi_pkg::REG_GAINP: kp = data[15:0];
      pidpi_pkg::REG_GAINI: ki = data[15:0];
      pidpi_pkg::REG_GAIND: kd = data[15:0];
      pidpi_pkg::REG_ALPHA: alpha = data[15:0];
      default: ;
    endcase
  endfunction

  function void take_error(logic [15:0] raw);
    logic signed [63:0] e, n, l, ll, p, i, d, a, acc, drv;
    e = $signed(raw);
    p = kp;
    i = ki;
    d = kd;
    a = {48'd0, alpha};
    n = err_cur;
    l = err_last;
    ll = err_last2;
    if (!mode_incr) begin
      acc = integ + e;
      if (acc > INTEG_MAX) acc = INTEG_MAX;
      if (acc < -INTEG_MAX) acc = -INTEG_MAX;
      integ = acc[15:0];
      acc = d * (e - l) * (64'sd65536 - a) + a * deriv;
      acc = clip32(round_q16(acc));
      deriv = acc[31:0];
      drv = p * e + i * integ + deriv;
      err_cur = e[19:0];
      err_last = e[19:0];
    end else begin
      ll = wrap20(round_q16(l * SCALE_092));
      l = wrap20(round_q16(n * SCALE_092));
      n = wrap20(round_q16(e * SCALE_108));
      drv = p * (n - l) + i * n + d * (n - 64'sd2 * l + ll);
      err_cur = n[19:0];
      err_last = l[19:0];
      err_last2 = ll[19:0];
    end
    drv = clip32(drv);
    drive_due.push_back(drv[31:0]);
  endfunction

  function void check_drive(logic [31:0] got);
    logic [31:0] want;
    if (drive_due.size() == 0) begin
      $display("%0t drive_value unexpected: expected none, actual %0d", $time, $signed(got));
      errors++;
    end else begin
      want = drive_due.pop_front();
      if (got !== want) begin
        $display("%0t drive_value mismatch: expected %0d, actual %0d",
                 $time, $signed(want), $signed(got));
        errors++;
      end
    end
  endfunction
endclass

module testbench;
  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 150;
  localparam int LONG_HOLD = 400;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  drive_scoreboard drive_sb;
  int unsigned     src_gap_pct;
  int unsigned     sink_stall_pct;
  bit              hold_long;

  pid_position_incremental u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    // go idle between transfers
    @(posedge clk);
    drive_sb.set_reg(idx, data);
  endtask

  // Offer one error sample, with an optional idle burst ahead of it
  task automatic drive_error(logic [15:0] e);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    drive_sb.take_error(e);
  endtask

  // Drain all outstanding drive values, then let the sequencer settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (drive_sb.drive_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 2048) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_error(bit neg_bias);
    int unsigned r;
    logic [15:0] v;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = 16'($urandom);
    end else if (r < 70) begin
      v = 16'($urandom_range(0, 400) - 200);
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: v = 16'h7FFF;
        1: v = 16'h8000;
        2: v = 16'h0000;
        default: v = 16'hFFFF;
      endcase
    end else begin
      // same-sign runs drive the integral into its clamp
      v = 16'($urandom_range(2000, 32767));
      if (neg_bias) v = -v;
    end
    return v;
  endfunction

  task automatic set_phase_config(int k);
    logic [15:0] gp, gi, gd, a;
    logic [31:0] junk;
    bit m;
    if (k < 2) begin
      gp = 16'h7FFF;
      gi = 16'h7FFF;
      gd = 16'h7FFF;
      a = 16'hFFFF;
      m = k[0];
    end else if (k < 4) begin
      gp = 16'h8000;
      gi = 16'h8000;
      gd = 16'h8000;
      a = 16'h0000;
      m = k[0];
    end else begin
      gp = pick_gain();
      gi = pick_gain();
      gd = pick_gain();
      case ($urandom_range(0, 2))
        0: a = 16'h0000;
        1: a = 16'hFFFF;
        default: a = 16'($urandom);
      endcase
      m = 1'($urandom_range(0, 1));
    end
    junk = $urandom;
    write_reg(pidpi_pkg::REG_MODE, {junk[31:1], m});
    junk = $urandom;
    write_reg(pidpi_pkg::REG_GAINP, {junk[31:16], gp});
    junk = $urandom;
    write_reg(pidpi_pkg::REG_GAINI, {junk[31:16], gi});
    junk = $urandom;
    write_reg(pidpi_pkg::REG_GAIND, {junk[31:16], gd});
    junk = $urandom;
    write_reg(pidpi_pkg::REG_ALPHA, {junk[31:16], a});
  endtask

  initial begin : sink
    int unsigned n;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        // hold off long enough for the block to back up into its input
        hold_long = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        n = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      drive_sb.check_drive(out_tdata);
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] dir[$];
    bit neg_bias;
    int k, j;
    drive_sb = new();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    hold_long = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // positional, largest gains, no filtering; unused index must be ignored
    write_reg(pidpi_pkg::REG_MODE, 32'h0000_0000);
    write_reg(pidpi_pkg::REG_GAINP, 32'h0000_7FFF);
    write_reg(pidpi_pkg::REG_GAINI, 32'h0000_7FFF);
    write_reg(pidpi_pkg::REG_GAIND, 32'h0000_7FFF);
    write_reg(pidpi_pkg::REG_ALPHA, 32'h0000_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    dir = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
            16'h0000, 16'h0001, 16'hFFFF, 16'h0010};
    foreach (dir[i]) drive_error(dir[i]);
    wait_idle();

    // most negative gains, heaviest filtering, junk in the upper bits
    write_reg(pidpi_pkg::REG_ALPHA, 32'hA5A5_FFFF);
    write_reg(pidpi_pkg::REG_GAINP, 32'hFFFF_8000);
    write_reg(pidpi_pkg::REG_GAINI, 32'h1234_8000);
    write_reg(pidpi_pkg::REG_GAIND, 32'h7FFF_8000);
    dir = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h0064};
    foreach (dir[i]) drive_error(dir[i]);
    wait_idle();

    // incremental on the shared history, swings large enough to saturate
    write_reg(pidpi_pkg::REG_MODE, 32'hFFFF_FFFF);
    write_reg(pidpi_pkg::REG_GAINP, 32'h0000_7FFF);
    write_reg(pidpi_pkg::REG_GAINI, 32'h0000_7FFF);
    write_reg(pidpi_pkg::REG_GAIND, 32'h0000_8000);
    dir = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
    foreach (dir[i]) drive_error(dir[i]);
    wait_idle();

    // back to positional with a half-weight filter
    write_reg(pidpi_pkg::REG_MODE, 32'hFFFF_FFFE);
    write_reg(pidpi_pkg::REG_ALPHA, 32'h0000_8000);
    write_reg(pidpi_pkg::REG_GAINP, 32'h0000_0100);
    dir = '{16'h8000, 16'h7FFF, 16'h0005};
    foreach (dir[i]) drive_error(dir[i]);
    wait_idle();

    for (k = 0; k < PHASES; k++) begin
      set_phase_config(k);
      if (k == PHASES - 1) begin
        src_gap_pct = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (k == 4) hold_long = 1'b1;
      neg_bias = 1'($urandom_range(0, 1));
      for (j = 0; j < PHASE_ITEMS; j++) begin
        if ($urandom_range(0, 49) == 0) neg_bias = ~neg_bias;
        drive_error(pick_error(neg_bias));
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (drive_sb.errors == 0 && drive_sb.drive_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
